FILE: hdl/fcsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsr_pkg
// Shared widths, limits and sequencer states for the filled circle span
// rasterizer.
// ----------------------------------------------------------------------------
package fcsr_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int MAX_RADIUS = 31;

    localparam int DIM_W   = 13;               // canvas size registers
    localparam int COORD_W = 14;               // signed centre coordinates
    localparam int RAD_W   = 6;                // signed radius
    localparam int ROOT_W  = $clog2(MAX_RADIUS + 1);
    localparam int RR_W    = 2 * ROOT_W;       // radius squared
    localparam int POS_W   = COORD_W + 1;      // signed working coordinate
    localparam int OUT_W   = 12;               // row and column outputs
    localparam int COL_W   = 8;
    localparam int IDX_W   = 1;

    localparam logic [IDX_W-1:0] REG_CANVAS_WIDTH  = 1'd0;
    localparam logic [IDX_W-1:0] REG_CANVAS_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] DIM_RESET = 13'd256;
    localparam logic [COL_W-1:0] WHITE     = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ROW,
        ST_SQRT,
        ST_CLIP,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
        logic [COL_W-1:0] alpha;
    } t_color;

    // Clamp a canvas size register to the largest supported canvas.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_DIM);
        return (d > lim) ? lim : d;
    endfunction

endpackage

FILE: hdl/filled_circle_span_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filled_circle_span_rasterizer
// Turns one brush request into clipped row spans of a filled circle.
// ----------------------------------------------------------------------------
// Each row visited goes through setup, square-root start, 5 root steps and
// clip, paced by the bit-per-cycle square-root unit; a request also waits
// on the output when it stalls.
// One request is in work at a time; a new one is taken once the last span
// has been loaded into the output register.
// Reset is synchronous, active low: sequencer idle, output empty, canvas 256x256.
module filled_circle_span_rasterizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [fcsr_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [fcsr_pkg::DIM_W-1:0]    i_cfg_wdata,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [fcsr_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [fcsr_pkg::COORD_W-1:0] i_center_y,
    input  logic signed [fcsr_pkg::RAD_W-1:0]   i_brush_radius,
    input  logic [fcsr_pkg::COL_W-1:0]    i_red_in,
    input  logic [fcsr_pkg::COL_W-1:0]    i_green_in,
    input  logic [fcsr_pkg::COL_W-1:0]    i_blue_in,
    input  logic [fcsr_pkg::COL_W-1:0]    i_alpha_in,
    input  logic                          i_erase,
    // span channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fcsr_pkg::OUT_W-1:0]    o_row,
    output logic [fcsr_pkg::OUT_W-1:0]    o_span_start,
    output logic [fcsr_pkg::OUT_W-1:0]    o_span_end,
    output logic [fcsr_pkg::COL_W-1:0]    o_red_out,
    output logic [fcsr_pkg::COL_W-1:0]    o_green_out,
    output logic [fcsr_pkg::COL_W-1:0]    o_blue_out,
    output logic [fcsr_pkg::COL_W-1:0]    o_alpha_out,
    output logic                          o_last_span
);
    import fcsr_pkg::*;

    t_state r_state, n_state;

    logic [DIM_W-1:0]          r_width, r_height;
    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic signed [RAD_W-1:0]   r_rad;
    t_color                    r_col;
    logic signed [POS_W-1:0]   r_y, r_y1;
    logic [RR_W-1:0]           r_rr;

    logic                      r_pend_valid;
    logic [OUT_W-1:0]          r_pend_row, r_pend_x0, r_pend_x1;

    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_out_row, r_out_x0, r_out_x1;
    t_color                    r_out_col;
    logic                      r_out_last;

    // sequencer strobes
    logic s_accept, s_sqrt_start, s_push, s_push_last, s_pend_load, s_y_inc;

    logic                    c_out_free;
    logic signed [POS_W-1:0] c_cx, c_cy, c_w_last, c_h_last, c_rad;
    logic [ROOT_W-1:0]       c_rad_sat;
    logic signed [POS_W-1:0] c_y0, c_y1, c_dy, c_x0, c_x1, c_root;
    logic [ROOT_W-1:0]       c_dy_abs;
    logic [RR_W-1:0]         c_radicand;
    logic                    c_on_canvas, c_span_ok;
    logic                    w_sqrt_done;
    logic [ROOT_W-1:0]       w_root;

    fcsr_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_sqrt_start),
        .i_radicand (c_radicand),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    // ---------------- geometry ----------------
    assign c_cx     = POS_W'(r_cx);
    assign c_cy     = POS_W'(r_cy);
    assign c_w_last = $signed(POS_W'(clamp_dim(r_width)))  - POS_W'(1);
    assign c_h_last = $signed(POS_W'(clamp_dim(r_height))) - POS_W'(1);

    assign c_rad_sat = (r_rad > $signed({1'b0, ROOT_W'(MAX_RADIUS)}))
                       ? ROOT_W'(MAX_RADIUS) : r_rad[ROOT_W-1:0];
    assign c_rad     = $signed(POS_W'(c_rad_sat));

    assign c_y0 = (c_cy - c_rad < 0) ? '0 : c_cy - c_rad;
    assign c_y1 = (c_cy + c_rad > c_h_last) ? c_h_last : c_cy + c_rad;

    assign c_on_canvas = (c_cx >= 0) && (c_cx <= c_w_last) &&
                         (c_cy >= 0) && (c_cy <= c_h_last);

    // |dy| never exceeds the radius inside the row loop
    assign c_dy       = r_y - c_cy;
    assign c_dy_abs   = c_dy[POS_W-1] ? ROOT_W'(-c_dy) : c_dy[ROOT_W-1:0];
    assign c_radicand = r_rr - RR_W'(c_dy_abs * c_dy_abs);

    assign c_root    = $signed(POS_W'(w_root));
    assign c_x0      = (c_cx - c_root < 0) ? '0 : c_cx - c_root;
    assign c_x1      = (c_cx + c_root > c_w_last) ? c_w_last : c_cx + c_root;
    assign c_span_ok = (c_x0 <= c_x1);

    assign c_out_free = !r_out_valid || !i_out_stall;

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        s_accept     = 1'b0;
        s_sqrt_start = 1'b0;
        s_push       = 1'b0;
        s_push_last  = 1'b0;
        s_pend_load  = 1'b0;
        s_y_inc      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    s_accept = 1'b1;
                    n_state  = ST_START;
                end
            end
            ST_START: begin
                n_state = (r_rad <= 0) ? ST_FLUSH : ST_ROW;
            end
            ST_ROW: begin
                if (r_y > r_y1) begin
                    n_state = ST_FLUSH;
                end else begin
                    s_sqrt_start = 1'b1;
                    n_state      = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (w_sqrt_done) begin
                    n_state = ST_CLIP;
                end
            end
            ST_CLIP: begin
                // hold the new span until the older pending one can leave
                if (!c_span_ok) begin
                    s_y_inc = 1'b1;
                    n_state = ST_ROW;
                end else if (!r_pend_valid || c_out_free) begin
                    s_push      = r_pend_valid;
                    s_pend_load = 1'b1;
                    s_y_inc     = 1'b1;
                    n_state     = ST_ROW;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (c_out_free) begin
                    s_push      = 1'b1;
                    s_push_last = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CANVAS_WIDTH:  r_width  <= i_cfg_wdata;
                REG_CANVAS_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- request and row state ----------------
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cx  <= i_center_x;
            r_cy  <= i_center_y;
            r_rad <= i_brush_radius;
            if (i_erase) begin
                r_col <= '{red: WHITE, green: WHITE, blue: WHITE, alpha: WHITE};
            end else begin
                r_col <= '{red: i_red_in, green: i_green_in,
                           blue: i_blue_in, alpha: i_alpha_in};
            end
        end
        if (r_state == ST_START) begin
            r_y  <= c_y0;
            r_y1 <= c_y1;
            r_rr <= RR_W'(c_rad_sat * c_rad_sat);
        end else if (s_y_inc) begin
            r_y <= r_y + POS_W'(1);
        end
    end

    // one span of lookahead so the final span can be flagged
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (r_state == ST_START) begin
            r_pend_valid <= (r_rad <= 0) && c_on_canvas;
        end else if (s_pend_load) begin
            r_pend_valid <= 1'b1;
        end else if (s_push_last) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_START) begin
            r_pend_row <= r_cy[OUT_W-1:0];
            r_pend_x0  <= r_cx[OUT_W-1:0];
            r_pend_x1  <= r_cx[OUT_W-1:0];
        end else if (s_pend_load) begin
            r_pend_row <= r_y[OUT_W-1:0];
            r_pend_x0  <= c_x0[OUT_W-1:0];
            r_pend_x1  <= c_x1[OUT_W-1:0];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_out_row  <= r_pend_row;
            r_out_x0   <= r_pend_x0;
            r_out_x1   <= r_pend_x1;
            r_out_col  <= r_col;
            r_out_last <= s_push_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row        = r_out_row;
    assign o_span_start = r_out_x0;
    assign o_span_end   = r_out_x1;
    assign o_red_out    = r_out_col.red;
    assign o_green_out  = r_out_col.green;
    assign o_blue_out   = r_out_col.blue;
    assign o_alpha_out  = r_out_col.alpha;
    assign o_last_span  = r_out_last;

endmodule

FILE: hdl/fcsr_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsr_isqrt
// Iterative integer square root: one result bit per cycle, decided by a
// single narrow square and compare.
// ----------------------------------------------------------------------------
module fcsr_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [fcsr_pkg::RR_W-1:0]  i_radicand,
    output logic                       o_done,
    output logic [fcsr_pkg::ROOT_W-1:0] o_root
);
    import fcsr_pkg::*;

    logic                       r_busy;
    logic                       r_done;
    logic [RR_W-1:0]            r_n;
    logic [ROOT_W-1:0]          r_root;
    logic [$clog2(ROOT_W)-1:0]  r_bit;

    logic [ROOT_W-1:0] c_trial;
    logic [RR_W-1:0]   c_sq;

    assign c_trial = r_root | (ROOT_W'(1) << r_bit);
    assign c_sq    = RR_W'(c_trial * c_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_radicand;
            r_root <= '0;
            r_bit  <= ($clog2(ROOT_W))'(ROOT_W - 1);
        end else if (r_busy) begin
            // keep the trial bit when its square still fits
            if (c_sq <= r_n) begin
                r_root <= c_trial;
            end
            if (r_bit != '0) begin
                r_bit <= r_bit - 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: hdl/fcsr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsr_checker
// Port-level checks for the filled circle span rasterizer.
// ----------------------------------------------------------------------------
module fcsr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [fcsr_pkg::OUT_W-1:0]    o_row,
    input logic [fcsr_pkg::OUT_W-1:0]    o_span_start,
    input logic [fcsr_pkg::OUT_W-1:0]    o_span_end,
    input logic                          o_last_span
);
    import fcsr_pkg::*;

    // after reset the output is empty and a request can be taken
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

    // a stalled span holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_row) && $stable(o_span_start) &&
            $stable(o_span_end) && $stable(o_last_span))
        else $error("stalled span changed");

    // spans are never empty
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_span_start <= o_span_end)
        else $error("span start beyond span end");

    // after a span that is not the last, the request is still in work or its
    // last span already sits at the output
    a_busy_after_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_span |=>
            o_in_stall || (o_out_valid && o_last_span))
        else $error("request finished without a last span");

endmodule

bind filled_circle_span_rasterizer fcsr_checker u_fcsr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_row        (o_row),
    .o_span_start (o_span_start),
    .o_span_end   (o_span_end),
    .o_last_span  (o_last_span)
);
